@@ hw/rtl/http_response_header_checker_top_defines.svh @@
// Assertion helpers for the response header checker
`ifndef HTTP_RESPONSE_HEADER_CHECKER_TOP_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_CHECKER_TOP_DEFINES_SVH
// assert an implication on every clock edge outside reset
`define HRC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// assert an implication whose consequent holds in the next cycle
`define HRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/hrc_pkg.sv @@
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants for the response header checker.
// ----------------------------------------------------------------------------
`default_nettype none
package hrc_pkg;
    localparam int COUNT_BITS = 32;
    localparam logic [15:0] MAX_HDR_RESET = 16'd4096;

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_CLOSE   = 2'd1;
    localparam logic [1:0] OP_FAIL    = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [1:0] K_BODY = 2'd0;
    localparam logic [1:0] K_HDR  = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_OVERFLOW = 4'd1;
    localparam logic [3:0] E_STATUS   = 4'd2;
    localparam logic [3:0] E_NON2XX   = 4'd3;
    localparam logic [3:0] E_COLON    = 4'd4;
    localparam logic [3:0] E_TE       = 4'd5;
    localparam logic [3:0] E_BADLEN   = 4'd6;
    localparam logic [3:0] E_CONFLICT = 4'd7;
    localparam logic [3:0] E_TOOLONG  = 4'd8;
    localparam logic [3:0] E_TRUNC    = 4'd9;
    localparam logic [3:0] E_CLOSEHDR = 4'd10;
    localparam logic [3:0] E_RXFAIL   = 4'd11;

    typedef enum logic [3:0] {
        PH_STATUS = 4'b0001,
        PH_FIELDS = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  body_byte;
        logic [9:0]  status_code;
        logic        has_length;
        logic [31:0] body_length;
        logic [3:0]  error_code;
        logic        last;
    } result_t;

    function automatic logic [7:0] te_char(input logic [4:0] p);
        logic [7:0] c;
        case (p)
            5'd0: c = "t"; 5'd1: c = "r"; 5'd2: c = "a"; 5'd3: c = "n";
            5'd4: c = "s"; 5'd5: c = "f"; 5'd6: c = "e"; 5'd7: c = "r";
            5'd8: c = "-"; 5'd9: c = "e"; 5'd10: c = "n"; 5'd11: c = "c";
            5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
            5'd16: c = "g";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cl_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0: c = "c"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "t";
            4'd4: c = "e"; 4'd5: c = "n"; 4'd6: c = "t"; 4'd7: c = "-";
            4'd8: c = "l"; 4'd9: c = "e"; 4'd10: c = "n"; 4'd11: c = "g";
            4'd12: c = "t"; 4'd13: c = "h";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] proto_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0: c = "H"; 3'd1: c = "T"; 3'd2: c = "T"; 3'd3: c = "P";
            3'd4: c = "/"; 3'd5: c = "1"; 3'd6: c = ".";
            default: c = 8'd0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/hrc_out_queue.sv @@
// ----------------------------------------------------------------------------
// hrc_out_queue
// Four-entry result queue that parts the parser from the output stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_response_header_checker_top_defines.svh"
module hrc_out_queue
    import hrc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push0,
    input  wire logic    push1,
    input  wire result_t din0,
    input  wire result_t din1,
    output logic         room,
    output logic         valid,
    input  wire logic    stall,
    output result_t      dout
);
    result_t    mem_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop   = valid && !stall;
    assign valid = cnt_reg != 3'd0;
    assign dout  = mem_reg[rd_reg];
    // two free slots needed for a worst-case item
    assign room  = cnt_reg <= 3'd2;

    always_comb
    begin
        cnt_next = cnt_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
    end

    // store pushed results
    always_ff @(posedge clk)
    begin
        if (push0)
            mem_reg[wr_reg] <= din0;
        if (push1)
            mem_reg[wr_reg + {1'b0, push0}] <= din1;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_reg + {1'b0, pop};
            wr_reg  <= wr_reg + {1'b0, push0} + {1'b0, push1};
            cnt_reg <= cnt_next;
        end
    end

    `HRC_ASSERT_IMPL(a_no_overflow, push0 || push1, cnt_reg <= 3'd2, "queue overrun")
    `HRC_ASSERT_IMPL(a_push_order, push1, push0, "second result without first")
    `HRC_ASSERT_IMPL(a_count_max, 1'b1, cnt_reg <= 3'd4, "queue count out of range")
endmodule
`default_nettype wire

@@ hw/rtl/http_response_header_checker_top.sv @@
// ----------------------------------------------------------------------------
// http_response_header_checker_top
// HTTP/1.x response header checker with body pass-through.
// ----------------------------------------------------------------------------
// One item is taken per cycle: each byte is checked by a single registered
// pass over the parser state, and any results (one or two) go into a four-deep
// result queue. Input is stalled only when that queue holds more than two
// results, so with the output side free the block runs at one item per cycle.
`default_nettype none
`include "http_response_header_checker_top_defines.svh"
module http_response_header_checker_top
    import hrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       body_byte,
    output logic [9:0]       status_code,
    output logic             has_length,
    output logic [31:0]      body_length,
    output logic [3:0]       error_code,
    output logic             last
);
    localparam logic [COUNT_BITS-1:0] CMASK = '1;

    logic [15:0]           max_reg;
    phase_t                ph_reg, ph_next;
    logic [15:0]           hc_reg, hc_next, lp_reg, lp_next;
    logic                  cr_reg, cr_next;
    logic [9:0]            sd_reg, sd_next;
    logic [1:0]            nm_reg, nm_next, vp_reg, vp_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next, len_reg, len_next, bc_reg, bc_next;
    logic                  ls_reg, ls_next;
    logic [3:0]            le_reg, le_next;

    logic    room, acc, push0, push1;
    result_t r0, r1, qo;

    assign in_stall = !room;
    assign acc      = in_valid && room;

    // process one content byte of a header line
    function automatic void content(input logic [7:0] b, input phase_t ph,
        inout logic [15:0] lp, inout logic [9:0] sd, inout logic [1:0] nm,
        inout logic [1:0] vp, inout logic [COUNT_BITS-1:0] ac,
        inout logic [3:0] le);
        logic [7:0] f;
        logic [3:0] d;
        logic       dig, ws;
        dig = b >= "0" && b <= "9";
        ws  = b == " " || b == 8'h09;
        d   = b[3:0];
        f   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (ph == PH_STATUS)
        begin
            if (lp < 16'd7)
            begin
                if (b != proto_char(lp[2:0]) && le == E_NONE) le = E_STATUS;
            end
            else if (lp == 16'd7)
            begin
                if (b != "0" && b != "1" && le == E_NONE) le = E_STATUS;
            end
            else if (lp == 16'd8 || lp == 16'd12)
            begin
                if (b != " " && le == E_NONE) le = E_STATUS;
            end
            else if (lp <= 16'd11)
            begin
                if (dig) sd = 10'((sd << 3) + (sd << 1) + {6'd0, d});
                else if (le == E_NONE) le = E_STATUS;
            end
        end
        else if (vp == 2'd0)
        begin
            if (b == ":")
            begin
                if (lp != 16'd17) nm[0] = 1'b0;
                if (lp != 16'd14) nm[1] = 1'b0;
                if (nm[0] && le == E_NONE) le = E_TE;
                vp = 2'd1;
            end
            else
            begin
                if (lp >= 16'd17 || f != te_char(lp[4:0])) nm[0] = 1'b0;
                if (lp >= 16'd14 || f != cl_char(lp[3:0])) nm[1] = 1'b0;
            end
        end
        else if (nm[1])
        begin
            if (vp == 2'd1)
            begin
                if (dig)
                begin
                    ac = COUNT_BITS'(d);
                    vp = 2'd2;
                end
                else if (!ws && le == E_NONE) le = E_BADLEN;
            end
            else if (vp == 2'd2)
            begin
                if (ws) vp = 2'd3;
                else if (!dig || ({4'd0, ac} * 10 + COUNT_BITS'(d)) > {4'd0, CMASK})
                begin
                    if (le == E_NONE) le = E_BADLEN;
                end
                else ac = COUNT_BITS'((ac << 3) + (ac << 1) + COUNT_BITS'(d));
            end
            else if (!ws && le == E_NONE) le = E_BADLEN;
        end
        if (lp != 16'hFFFF) lp = lp + 16'd1;
    endfunction

    // compute next state and results
    always_comb
    begin
        logic end_hdr;
        ph_next = ph_reg; hc_next = hc_reg; lp_next = lp_reg; cr_next = cr_reg;
        sd_next = sd_reg; nm_next = nm_reg; vp_next = vp_reg; acc_next = acc_reg;
        ls_next = ls_reg; len_next = len_reg; bc_next = bc_reg; le_next = le_reg;
        push0 = 1'b0; push1 = 1'b0; end_hdr = 1'b0;
        r0 = '0; r1 = '0;
        if (acc)
        begin
            if (operation == OP_RESTART)
            begin
                ph_next = PH_STATUS; hc_next = '0; cr_next = 1'b0; sd_next = '0;
                ls_next = 1'b0; len_next = '0; bc_next = '0; le_next = E_NONE;
                lp_next = '0; vp_next = '0; nm_next = 2'b11; acc_next = '0;
            end
            else if (ph_reg == PH_BODY)
            begin
                push0 = 1'b1; r0.last = 1'b1;
                if (operation == OP_DATA)
                begin
                    if (ls_reg && bc_reg >= len_reg)
                    begin
                        ph_next = PH_DONE; r0.kind = K_ERR; r0.error_code = E_TOOLONG;
                    end
                    else
                    begin
                        if (bc_reg != CMASK) bc_next = bc_reg + 1'b1;
                        r0.kind = K_BODY; r0.body_byte = byte_value;
                        if (ls_reg && bc_next == len_reg)
                        begin
                            ph_next = PH_DONE; r0.last = 1'b0;
                            push1 = 1'b1; r1.kind = K_DONE; r1.last = 1'b1;
                        end
                    end
                end
                else
                begin
                    ph_next = PH_DONE;
                    if (ls_reg && bc_reg != len_reg)
                    begin
                        r0.kind = K_ERR; r0.error_code = E_TRUNC;
                    end
                    else if (operation == OP_FAIL)
                    begin
                        r0.kind = K_ERR; r0.error_code = E_RXFAIL;
                    end
                    else r0.kind = K_DONE;
                end
            end
            else if (ph_reg != PH_DONE)
            begin
                if (operation != OP_DATA)
                begin
                    ph_next = PH_DONE; push0 = 1'b1; r0.kind = K_ERR; r0.last = 1'b1;
                    r0.error_code = (operation == OP_CLOSE) ? E_CLOSEHDR : E_RXFAIL;
                end
                else
                begin
                    if (hc_reg != 16'hFFFF) hc_next = hc_reg + 16'd1;
                    if (cr_reg && byte_value == 8'h0A)
                    begin
                        cr_next = 1'b0;
                        if (ph_reg == PH_STATUS)
                        begin
                            if (lp_reg < 16'd12)
                            begin
                                if (le_next == E_NONE) le_next = E_STATUS;
                            end
                            else if ((sd_reg < 10'd200 || sd_reg >= 10'd300)
                                     && le_next == E_NONE)
                                le_next = E_NON2XX;
                            ph_next = PH_FIELDS;
                        end
                        else if (lp_reg == 16'd0)
                            end_hdr = 1'b1;
                        else if (vp_reg == 2'd0)
                        begin
                            if (le_next == E_NONE) le_next = E_COLON;
                        end
                        else if (nm_reg[1])
                        begin
                            if (vp_reg == 2'd1)
                            begin
                                if (le_next == E_NONE) le_next = E_BADLEN;
                            end
                            else if (le_next == E_NONE)
                            begin
                                if (ls_reg && acc_reg != len_reg) le_next = E_CONFLICT;
                                else
                                begin
                                    ls_next = 1'b1; len_next = acc_reg;
                                end
                            end
                        end
                        lp_next = '0; vp_next = '0; nm_next = 2'b11; acc_next = '0;
                    end
                    else
                    begin
                        if (cr_reg)
                            content(8'h0D, ph_reg, lp_next, sd_next, nm_next,
                                    vp_next, acc_next, le_next);
                        cr_next = byte_value == 8'h0D;
                        if (byte_value != 8'h0D)
                            content(byte_value, ph_reg, lp_next, sd_next, nm_next,
                                    vp_next, acc_next, le_next);
                    end
                    if (end_hdr && hc_next <= max_reg)
                    begin
                        push0 = 1'b1; r0.last = 1'b1;
                        if (le_next != E_NONE)
                        begin
                            ph_next = PH_DONE; r0.kind = K_ERR; r0.error_code = le_next;
                        end
                        else
                        begin
                            ph_next = PH_BODY; bc_next = '0; r0.kind = K_HDR;
                            if (ls_next && len_next == '0)
                            begin
                                ph_next = PH_DONE; r0.last = 1'b0; push1 = 1'b1;
                                r1.kind = K_DONE; r1.last = 1'b1;
                            end
                        end
                    end
                    else if (end_hdr || hc_next >= max_reg)
                    begin
                        ph_next = PH_DONE; push0 = 1'b1; r0.kind = K_ERR; r0.last = 1'b1;
                        r0.error_code = (le_next != E_NONE) ? le_next : E_OVERFLOW;
                    end
                end
            end
        end
        // common fields come from the updated state
        r0.status_code = sd_next; r1.status_code = sd_next;
        r0.has_length = ls_next; r1.has_length = ls_next;
        r0.body_length = 32'(len_next); r1.body_length = 32'(len_next);
    end

    // hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_HDR_RESET; ph_reg <= PH_STATUS; hc_reg <= '0; lp_reg <= '0;
            cr_reg <= 1'b0; sd_reg <= '0; nm_reg <= 2'b11; vp_reg <= '0;
            acc_reg <= '0; ls_reg <= 1'b0; len_reg <= '0; bc_reg <= '0;
            le_reg <= E_NONE;
        end
        else
        begin
            if (cfg_we) max_reg <= cfg_wdata;
            ph_reg <= ph_next; hc_reg <= hc_next; lp_reg <= lp_next; cr_reg <= cr_next;
            sd_reg <= sd_next; nm_reg <= nm_next; vp_reg <= vp_next;
            acc_reg <= acc_next; ls_reg <= ls_next; len_reg <= len_next;
            bc_reg <= bc_next; le_reg <= le_next;
        end
    end

    hrc_out_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push0(push0), .push1(push1), .din0(r0),
        .din1(r1), .room(room), .valid(out_valid), .stall(out_stall), .dout(qo)
    );

    assign kind = qo.kind; assign body_byte = qo.body_byte;
    assign status_code = qo.status_code; assign has_length = qo.has_length;
    assign body_length = qo.body_length; assign error_code = qo.error_code;
    assign last = qo.last;

    `HRC_ASSERT_NEXT(a_done_quiet, ph_reg == PH_DONE && !(acc && operation == OP_RESTART),
                     ph_reg == PH_DONE, "left done without restart")
    `HRC_ASSERT_IMPL(a_body_len, ph_reg == PH_BODY && ls_reg, bc_reg <= len_reg,
                     "body count beyond length")
    `HRC_ASSERT_IMPL(a_err_code, push0 && r0.kind == K_ERR, r0.error_code != E_NONE,
                     "error result without code")
endmodule
`default_nettype wire
